/* rtl/core/slr_pkg.sv */
// ----------------------------------------------------------------------------
// slr_pkg
// Shared types and constants of the styled line rasterizer.
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned DEC_BITS   = COORD_BITS + 3;
  localparam int unsigned STEP_BITS  = COORD_BITS + 1;
  localparam int unsigned PAT_BITS   = 5;
  localparam int unsigned RGB_BITS   = 24;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RGB_BITS-1:0] COLOR_GREEN  = 24'h00FF00;
  localparam logic [RGB_BITS-1:0] COLOR_CYAN   = 24'h00FFFF;
  localparam logic [RGB_BITS-1:0] COLOR_YELLOW = 24'hFFFF00;
  localparam logic [RGB_BITS-1:0] COLOR_NONE   = 24'h000000;

  // Dash-dot pattern marks
  localparam logic [PAT_BITS-1:0] PAT_DASH_END = 5'd10;
  localparam logic [PAT_BITS-1:0] PAT_DOT      = 5'd15;
  localparam logic [PAT_BITS-1:0] PAT_WRAP     = 5'd20;
  localparam logic [PAT_BITS-1:0] PAT_FIRST    = 5'd1;
  localparam logic [PAT_BITS-1:0] PAT_AFTER_WRAP = 5'd2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } slr_op_e;

  typedef enum logic [1:0] {
    STYLE_SOLID   = 2'd0,
    STYLE_DOTTED  = 2'd1,
    STYLE_DASHED  = 2'd2,
    STYLE_DASHDOT = 2'd3
  } slr_style_e;

  typedef struct packed {
    slr_op_e                opcode;
    logic [COORD_BITS-1:0]  start_x;
    logic [COORD_BITS-1:0]  start_y;
    logic [COORD_BITS-1:0]  end_x;
    logic [COORD_BITS-1:0]  end_y;
    slr_style_e             line_style;
  } slr_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    logic                   plot;
    logic [RGB_BITS-1:0]    rgb_color;
    logic                   last_step;
  } slr_out_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    slr_op_e                opcode;
    logic [COORD_BITS-1:0]  start_x;
    logic [COORD_BITS-1:0]  start_y;
    logic [COORD_BITS-1:0]  major_delta;
    logic [COORD_BITS-1:0]  minor_delta;
    logic [DEC_BITS-1:0]    decision;
    logic [1:0]             x_sign;
    logic [1:0]             y_sign;
    logic                   swapped;
    slr_style_e             style;
  } slr_cmd_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic not_empty;
  } slr_qstat_t;

endpackage

/* rtl/core/slr_front.sv */
// ----------------------------------------------------------------------------
// slr_front
// Accepts items, classifies them and precomputes the Bresenham setup.
// ----------------------------------------------------------------------------
module slr_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  slr_pkg::slr_in_t  in_data_i,
  input  slr_pkg::slr_qstat_t qstat_i,
  output logic              push_o,
  output slr_pkg::slr_cmd_t cmd_o
);
  import slr_pkg::*;

  logic [COORD_BITS-1:0] dx, dy;
  logic [1:0]            xs, ys;
  logic                  swap;
  logic [COORD_BITS-1:0] major, minor;

  always_comb begin
    if (in_data_i.end_x > in_data_i.start_x) begin
      dx = in_data_i.end_x - in_data_i.start_x;
      xs = 2'b01;
    end else if (in_data_i.end_x < in_data_i.start_x) begin
      dx = in_data_i.start_x - in_data_i.end_x;
      xs = 2'b11;
    end else begin
      dx = '0;
      xs = 2'b00;
    end
    if (in_data_i.end_y > in_data_i.start_y) begin
      dy = in_data_i.end_y - in_data_i.start_y;
      ys = 2'b01;
    end else if (in_data_i.end_y < in_data_i.start_y) begin
      dy = in_data_i.start_y - in_data_i.end_y;
      ys = 2'b11;
    end else begin
      dy = '0;
      ys = 2'b00;
    end
    swap  = dy > dx;
    major = swap ? dy : dx;
    minor = swap ? dx : dy;
  end

  assign in_ready_o = !qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full;

  always_comb begin
    cmd_o.opcode      = in_data_i.opcode;
    cmd_o.start_x     = in_data_i.start_x;
    cmd_o.start_y     = in_data_i.start_y;
    cmd_o.major_delta = major;
    cmd_o.minor_delta = minor;
    // 2*minor - major
    cmd_o.decision    = {2'b00, minor, 1'b0} - {3'b000, major};
    cmd_o.x_sign      = xs;
    cmd_o.y_sign      = ys;
    cmd_o.swapped     = swap;
    cmd_o.style       = in_data_i.line_style;
  end

endmodule

/* rtl/core/slr_queue.sv */
// ----------------------------------------------------------------------------
// slr_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module slr_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  slr_pkg::slr_cmd_t   push_cmd_i,
  input  logic                pop_i,
  output slr_pkg::slr_cmd_t   head_o,
  output slr_pkg::slr_qstat_t qstat_o
);
  import slr_pkg::*;

  slr_cmd_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign head_o            = mem_q[rd_ptr_q];
  assign qstat_o.full      = count_q == QCNT_BITS'(QUEUE_DEPTH);
  assign qstat_o.not_empty = count_q != '0;

endmodule

/* rtl/core/slr_back.sv */
// ----------------------------------------------------------------------------
// slr_back
// Latches a line on each start command, walks it one step per step command and holds the result register.
// ----------------------------------------------------------------------------
module slr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slr_pkg::slr_qstat_t qstat_i,
  input  slr_pkg::slr_cmd_t   head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slr_pkg::slr_out_t   out_data_o
);
  import slr_pkg::*;

  logic [COORD_BITS-1:0] cur_x_q, cur_x_d;
  logic [COORD_BITS-1:0] cur_y_q, cur_y_d;
  logic [DEC_BITS-1:0]   dec_q, dec_d;
  logic [COORD_BITS-1:0] major_q, major_d;
  logic [COORD_BITS-1:0] minor_q, minor_d;
  logic [STEP_BITS-1:0]  step_idx_q, step_idx_d;
  logic [1:0]            xs_q, xs_d;
  logic [1:0]            ys_q, ys_d;
  logic                  swap_q, swap_d;
  slr_style_e            style_q, style_d;
  logic [PAT_BITS-1:0]   pat_q, pat_d;
  logic                  active_q, active_d;
  logic                  out_valid_q, out_valid_d;
  slr_out_t              out_q, out_d;

  logic                  slot_free;
  logic                  has_result;
  logic                  fire;
  logic                  plot;
  logic [RGB_BITS-1:0]   color;
  logic [PAT_BITS-1:0]   pat_step;
  logic                  last;
  logic                  dec_pos;
  logic [COORD_BITS-1:0] x_moved, y_moved;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign has_result = (head_i.opcode == OP_STEP) && active_q;
  assign fire       = qstat_i.not_empty && (!has_result || slot_free);
  assign pop_o      = fire;

  // Style pattern for the current step
  always_comb begin
    plot     = 1'b0;
    color    = COLOR_NONE;
    pat_step = pat_q;
    case (style_q)
      STYLE_SOLID: begin
        plot  = 1'b1;
        color = COLOR_GREEN;
      end
      STYLE_DOTTED: begin
        if (!step_idx_q[0]) begin
          plot  = 1'b1;
          color = COLOR_GREEN;
        end
      end
      STYLE_DASHED: begin
        if (pat_q inside {PAT_BITS'(0), PAT_DASH_END, PAT_WRAP, PAT_BITS'(30)}) begin
          pat_step = PAT_FIRST;
        end else begin
          plot     = 1'b1;
          color    = COLOR_CYAN;
          pat_step = pat_q + 1'b1;
        end
      end
      default: begin
        pat_step = pat_q + 1'b1;
        if (pat_q inside {[PAT_FIRST:PAT_DASH_END - 1'b1]}) begin
          plot  = 1'b1;
          color = COLOR_GREEN;
        end else if (pat_q == PAT_DOT) begin
          plot  = 1'b1;
          color = COLOR_YELLOW;
        end else if (pat_q == PAT_WRAP) begin
          pat_step = PAT_AFTER_WRAP;
        end
      end
    endcase
  end

  assign last    = step_idx_q >= {1'b0, major_q};
  assign dec_pos = !dec_q[DEC_BITS-1];
  assign x_moved = cur_x_q + {{(COORD_BITS-2){xs_q[1]}}, xs_q};
  assign y_moved = cur_y_q + {{(COORD_BITS-2){ys_q[1]}}, ys_q};

  always_comb begin
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    dec_d      = dec_q;
    major_d    = major_q;
    minor_d    = minor_q;
    step_idx_d = step_idx_q;
    xs_d       = xs_q;
    ys_d       = ys_q;
    swap_d     = swap_q;
    style_d    = style_q;
    pat_d      = pat_q;
    active_d   = active_q;
    out_d      = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (fire) begin
      if (head_i.opcode == OP_START) begin
        cur_x_d    = head_i.start_x;
        cur_y_d    = head_i.start_y;
        dec_d      = head_i.decision;
        major_d    = head_i.major_delta;
        minor_d    = head_i.minor_delta;
        xs_d       = head_i.x_sign;
        ys_d       = head_i.y_sign;
        swap_d     = head_i.swapped;
        style_d    = head_i.style;
        step_idx_d = STEP_BITS'(1);
        pat_d      = PAT_FIRST;
        active_d   = head_i.major_delta != '0;
      end else if (active_q) begin
        out_valid_d       = 1'b1;
        out_d.pixel_x     = cur_x_q;
        out_d.pixel_y     = cur_y_q;
        out_d.plot        = plot;
        out_d.rgb_color   = color;
        out_d.last_step   = last;
        pat_d             = pat_step;
        // Advance on the major axis, and on the minor axis when the term is not negative
        if (swap_q) begin
          cur_y_d = y_moved;
          if (dec_pos) cur_x_d = x_moved;
        end else begin
          cur_x_d = x_moved;
          if (dec_pos) cur_y_d = y_moved;
        end
        dec_d = dec_q + {2'b00, minor_q, 1'b0}
                - (dec_pos ? {2'b00, major_q, 1'b0} : {DEC_BITS{1'b0}});
        if (last) begin
          active_d = 1'b0;
        end else begin
          step_idx_d = step_idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      dec_q       <= '0;
      major_q     <= '0;
      minor_q     <= '0;
      step_idx_q  <= STEP_BITS'(1);
      xs_q        <= '0;
      ys_q        <= '0;
      swap_q      <= 1'b0;
      style_q     <= STYLE_SOLID;
      pat_q       <= PAT_FIRST;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      dec_q       <= dec_d;
      major_q     <= major_d;
      minor_q     <= minor_d;
      step_idx_q  <= step_idx_d;
      xs_q        <= xs_d;
      ys_q        <= ys_d;
      swap_q      <= swap_d;
      style_q     <= style_d;
      pat_q       <= pat_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/styled_line_rasterizer_core.sv */
// ----------------------------------------------------------------------------
// styled_line_rasterizer_core
// Styled Bresenham line stepper with a decoupled front and back.
// ----------------------------------------------------------------------------
// A start item latches two endpoints and a style and gives no result; each
// step item then gives one pixel (position, plot flag, color, last mark) until
// the line's major delta is used up, the end point itself not being drawn.
// Items are taken at one per cycle while the queue is not full: the front computes
// the setup in the cycle it accepts an item and writes a two-entry queue, and the
// back retires one queue entry per cycle, limited only by its single output
// register. A step item's result passes through the queue and then the output register.
module styled_line_rasterizer_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  slr_pkg::slr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output slr_pkg::slr_out_t out_data_o
);
  import slr_pkg::*;

  slr_qstat_t qstat;
  slr_cmd_t   push_cmd;
  slr_cmd_t   head;
  logic       push;
  logic       pop;

  slr_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  slr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .qstat_o    (qstat)
  );

  slr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/core/slr_checker.sv */
// ----------------------------------------------------------------------------
// slr_checker
// Port-level checks of the styled line rasterizer.
// ----------------------------------------------------------------------------
module slr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input slr_pkg::slr_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input slr_pkg::slr_out_t out_data_o
);
  import slr_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_no_color_when_skipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.plot |-> out_data_o.rgb_color == COLOR_NONE)
    else $error("color on a skipped pixel");

  a_known_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.plot |->
      out_data_o.rgb_color == COLOR_GREEN || out_data_o.rgb_color == COLOR_CYAN ||
      out_data_o.rgb_color == COLOR_YELLOW)
    else $error("unexpected pixel color");

  // A start item taken in the first cycle out of reset produces no result in the next cycle
  a_start_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) && !out_valid_o && in_valid_i && in_ready_o &&
    in_data_i.opcode == OP_START |=> !out_valid_o)
    else $error("result after start from reset");

endmodule

bind styled_line_rasterizer_core slr_checker u_slr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for styled_line_rasterizer_core.
// ----------------------------------------------------------------------------
// A line scoreboard walks every accepted start and step item through its own
// Bresenham stepper and style pattern, and queues the pixel each step should
// give. Every pixel the block hands out is checked field by field against
// the oldest queued one. Stimulus is a few hand-picked lines, then random
// lines that mostly run to their end, with starts cut short, extra steps
// while idle and noise mixed in. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module testbench;
  import slr_pkg::*;

  localparam int ITEM_TARGET = 1400;
  localparam int CALM_AFTER  = 1200;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 16;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

  class line_scoreboard;
    slr_out_t pending[$];
    int errors;
    logic [COORD_BITS-1:0] cur_x, cur_y;
    int decision, major, minor, step_no, x_sign, y_sign, pattern;
    bit swapped, active;
    slr_style_e style;

    function new();
      cur_x = '0;
      cur_y = '0;
      decision = 0;
      major = 0;
      minor = 0;
      step_no = 1;
      x_sign = 0;
      y_sign = 0;
      swapped = 1'b0;
      style = STYLE_SOLID;
      pattern = 1;
      active = 1'b0;
      errors = 0;
    endfunction

    function void axis(input int a, input int b, output int d, output int s);
      if (b > a) begin
        d = b - a;
        s = 1;
      end else if (b < a) begin
        d = a - b;
        s = -1;
      end else begin
        d = 0;
        s = 0;
      end
    endfunction

    function logic [COORD_BITS-1:0] nudge(logic [COORD_BITS-1:0] c, int s);
      if (s > 0) return c + 1'b1;
      if (s < 0) return c - 1'b1;
      return c;
    endfunction

    // Returns 1 when the item starts a line or yields a pixel.
    function bit note_item(slr_in_t it);
      int dx, dy;
      slr_out_t px;
      if (it.opcode == OP_START) begin
        axis(int'(it.start_x), int'(it.end_x), dx, x_sign);
        axis(int'(it.start_y), int'(it.end_y), dy, y_sign);
        cur_x = it.start_x;
        cur_y = it.start_y;
        swapped = dy > dx;
        major = swapped ? dy : dx;
        minor = swapped ? dx : dy;
        decision = 2 * minor - major;
        step_no = 1;
        pattern = 1;
        style = it.line_style;
        active = major != 0;
        return 1'b1;
      end
      if (!active) return 1'b0;

      px.plot = 1'b0;
      px.rgb_color = COLOR_NONE;
      case (style)
        STYLE_SOLID: begin
          px.plot = 1'b1;
          px.rgb_color = COLOR_GREEN;
        end
        STYLE_DOTTED: begin
          if (step_no % 2 == 0) begin
            px.plot = 1'b1;
            px.rgb_color = COLOR_GREEN;
          end
        end
        STYLE_DASHED: begin
          if (pattern % int'(PAT_DASH_END) != 0) begin
            px.plot = 1'b1;
            px.rgb_color = COLOR_CYAN;
          end else begin
            pattern = 0;
          end
          pattern++;
        end
        default: begin
          if (pattern > 0 && pattern < int'(PAT_DASH_END)) begin
            px.plot = 1'b1;
            px.rgb_color = COLOR_GREEN;
          end else if (pattern == int'(PAT_DOT)) begin
            px.plot = 1'b1;
            px.rgb_color = COLOR_YELLOW;
          end else if (pattern == int'(PAT_WRAP)) begin
            pattern = int'(PAT_FIRST);
          end
          pattern++;
        end
      endcase
      pattern &= 31;

      px.pixel_x = cur_x;
      px.pixel_y = cur_y;
      px.last_step = step_no >= major;
      pending.push_back(px);

      // Minor-axis correction first, then the major-axis move
      if (decision >= 0) begin
        if (swapped) cur_x = nudge(cur_x, x_sign);
        else cur_y = nudge(cur_y, y_sign);
        decision -= 2 * major;
      end
      if (swapped) cur_y = nudge(cur_y, y_sign);
      else cur_x = nudge(cur_x, x_sign);
      decision += 2 * minor;

      if (px.last_step) active = 1'b0;
      else step_no++;
      return 1'b1;
    endfunction

    function void check_pixel(slr_out_t got);
      slr_out_t want;
      if (pending.size() == 0) begin
        $error("unexpected pixel: x %0d y %0d", got.pixel_x, got.pixel_y);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.pixel_x !== want.pixel_x) begin
        $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
        errors++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
        errors++;
      end
      if (got.plot !== want.plot) begin
        $error("plot: expected %0b, got %0b", want.plot, got.plot);
        errors++;
      end
      if (got.rgb_color !== want.rgb_color) begin
        $error("rgb_color: expected %06h, got %06h", want.rgb_color, got.rgb_color);
        errors++;
      end
      if (got.last_step !== want.last_step) begin
        $error("last_step: expected %0b, got %0b", want.last_step, got.last_step);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  slr_in_t   in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  slr_out_t  out_data;

  line_scoreboard sb = new();
  int counted = 0;
  bit calm = 1'b0;

  styled_line_rasterizer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_pixel(out_data);
  end

  function automatic slr_in_t start_item(int x0, int y0, int x1, int y1, slr_style_e st);
    slr_in_t it;
    it.opcode = OP_START;
    it.start_x = COORD_BITS'(x0);
    it.start_y = COORD_BITS'(y0);
    it.end_x = COORD_BITS'(x1);
    it.end_y = COORD_BITS'(y1);
    it.line_style = st;
    return it;
  endfunction

  // Fully random item, opcode included.
  function automatic slr_in_t noise_item();
    slr_in_t it;
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    it = noise[$bits(slr_in_t)-1:0];
    return it;
  endfunction

  // Step items carry random junk in the unused fields.
  function automatic slr_in_t step_item();
    slr_in_t it;
    it = noise_item();
    it.opcode = OP_STEP;
    return it;
  endfunction

  function automatic int far_end(int a, int d);
    int b;
    b = $urandom_range(0, 1) ? a + d : a - d;
    if (b > COORD_MAX || b < 0) b = (b > a) ? a - d : a + d;
    return b;
  endfunction

  task automatic send_item(slr_in_t it, bit gappy);
    if (gappy && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (sb.note_item(it)) counted++;
    calm = counted >= CALM_AFTER;
  endtask

  // Hold off the sender until every queued pixel is out.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic walk_random_line();
    int pick, len, side, dx, dy, x0, y0, steps;
    bit gappy;
    pick = $urandom_range(0, 99);
    len = pick < 70 ? $urandom_range(1, 40) :
          pick < 95 ? $urandom_range(41, 120) : $urandom_range(121, 400);
    pick = $urandom_range(0, 99);
    side = pick < 15 ? 0 : pick < 30 ? len : $urandom_range(0, len);
    if ($urandom_range(0, 1)) begin
      dx = len;
      dy = side;
    end else begin
      dx = side;
      dy = len;
    end
    x0 = $urandom_range(0, COORD_MAX);
    y0 = $urandom_range(0, COORD_MAX);
    steps = len;
    if ($urandom_range(0, 99) < 15) steps = $urandom_range(1, len);
    if ($urandom_range(0, 99) < 20) steps += $urandom_range(1, 2);
    gappy = $urandom_range(0, 2) != 0;
    send_item(start_item(x0, y0, far_end(x0, dx), far_end(y0, dy),
                         slr_style_e'($urandom_range(0, 3))), gappy);
    repeat (steps) send_item(step_item(), gappy);
  endtask

  initial begin
    int pick, line_no;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Step while idle, then a zero-length line
    send_item(step_item(), 1'b0);
    send_item(start_item(0, 0, 0, 0, STYLE_SOLID), 1'b0);
    send_item(step_item(), 1'b0);
    // Steep line walking down and left from the far corner
    send_item(start_item(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 3, STYLE_DOTTED),
              1'b0);
    repeat (3) send_item(step_item(), 1'b0);
    // Full diagonal dropped by a new start, then a step past the end
    send_item(start_item(0, 0, COORD_MAX, COORD_MAX, STYLE_SOLID), 1'b0);
    repeat (2) send_item(step_item(), 1'b0);
    send_item(start_item(COORD_MAX, 0, COORD_MAX - 3, 0, STYLE_DASHED), 1'b0);
    repeat (4) send_item(step_item(), 1'b0);
    send_item(start_item(5, 0, 5, 2, STYLE_DASHDOT), 1'b0);
    repeat (2) send_item(step_item(), 1'b0);
    drain_pixels();

    line_no = 0;
    while (counted < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        walk_random_line();
      end else if (pick < 92) begin
        send_item(noise_item(), 1'b1);
        repeat ($urandom_range(0, 3)) send_item(step_item(), 1'b1);
      end else begin
        send_item(step_item(), 1'b1);
      end
      line_no++;
      if (line_no % 40 == 0) drain_pixels();
    end

    drain_pixels();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d pixels never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("styled_line_rasterizer_core regression: pass");
    else $display("styled_line_rasterizer_core regression: fail");
    $finish;
  end

  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // Count cycles in which neither side moves an item.
  initial begin
    int stalled;
    stalled = 0;
    wait (rst_n);
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stalled = 0;
      else stalled++;
    end
    $display("styled_line_rasterizer_core regression: fail");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/slr_pkg.sv
rtl/core/slr_front.sv
rtl/core/slr_queue.sv
rtl/core/slr_back.sv
rtl/core/styled_line_rasterizer_core.sv
rtl/core/slr_checker.sv
test/testbench.sv
